FILE: hdl/bts_pkg.sv
package bts_pkg;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_PRESENT = 2'd2;

	localparam int TEXEL_W = 24;
	localparam int ADDR_W  = 16;
	localparam int FRAC_W  = 16;

	// Job handed from the front end to the back end through the queue.
	typedef struct packed {
		logic              is_sample;
		logic              present;
		logic [ADDR_W-1:0] addr0;
		logic [ADDR_W-1:0] addr1;
		logic [ADDR_W-1:0] addr2;
		logic [ADDR_W-1:0] addr3;
		logic [FRAC_W:0]   wx0;
		logic [FRAC_W:0]   wx1;
		logic [FRAC_W:0]   wy0;
		logic [FRAC_W:0]   wy1;
	} bts_job_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        was_sample;
	} bts_result_t;

endpackage

FILE: hdl/bts_ram.sv
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hdl/bts_front.sv
module bts_front
	import bts_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] texel_address,
	input  logic [16:0] u_coord,
	input  logic [16:0] v_coord,
	input  logic [8:0]  tex_width,
	input  logic [8:0]  tex_height,
	input  logic        texture_present,
	output logic        job_valid,
	input  logic        job_ready,
	output bts_job_t    job
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int PROD_W = 17 + DIM_W;
	localparam int CRD_W = PROD_W - FRAC_W;

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [PROD_W-1:0] su, sv;

	// Stage 1: scale coordinates.
	logic              valid_s1, sample_s1, present_s1;
	logic [15:0]       addr_s1;
	logic [PROD_W-1:0] su_s1, sv_s1;
	logic [DIM_W-1:0]  w_s1, h_s1;
	logic              adv_s1, adv_s2;

	// Stage 2: clamped coordinates and weights.
	logic              valid_s2;
	bts_job_t          job_s2;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [8:0] d);
		if (d == 9'd0) begin
			return DIM_W'(1);
		end else if (32'(d) > 32'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(d);
	endfunction

	always_comb begin
		w_eff = eff_dim(tex_width);
		h_eff = eff_dim(tex_height);
		su = PROD_W'(u_coord) * PROD_W'(w_eff);
		sv = PROD_W'(v_coord) * PROD_W'(h_eff);
	end

	assign adv_s2   = !valid_s2 || job_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sample_s1  <= (mode == MODE_SAMPLE);
			present_s1 <= texture_present;
			addr_s1    <= texel_address;
			su_s1      <= su;
			sv_s1      <= sv;
			w_s1       <= w_eff;
			h_s1       <= h_eff;
		end
	end

	logic [CRD_W:0]    x0, x1, y0, y1, wl, hl;
	logic [FRAC_W-1:0] fx, fy;
	logic [CRD_W+DIM_W:0] row0, row1;
	bts_job_t          nj;

	always_comb begin
		wl = (CRD_W + 1)'(w_s1) - 1'b1;
		hl = (CRD_W + 1)'(h_s1) - 1'b1;
		x0 = (CRD_W + 1)'(su_s1[PROD_W-1:FRAC_W]);
		y0 = (CRD_W + 1)'(sv_s1[PROD_W-1:FRAC_W]);
		fx = su_s1[FRAC_W-1:0];
		fy = sv_s1[FRAC_W-1:0];
		x1 = x0 + 1'b1;
		y1 = y0 + 1'b1;
		if (x0 > wl) x0 = wl;
		if (x1 > wl) x1 = wl;
		if (y0 > hl) y0 = hl;
		if (y1 > hl) y1 = hl;
		row0 = (CRD_W + DIM_W + 1)'(y0 * w_s1);
		row1 = (CRD_W + DIM_W + 1)'(y1 * w_s1);
		nj.is_sample = sample_s1;
		nj.present   = present_s1;
		if (sample_s1) begin
			nj.addr0 = ADDR_W'(row0 + (CRD_W + DIM_W + 1)'(x0));
		end else begin
			nj.addr0 = addr_s1;
		end
		nj.addr1 = ADDR_W'(row0 + (CRD_W + DIM_W + 1)'(x1));
		nj.addr2 = ADDR_W'(row1 + (CRD_W + DIM_W + 1)'(x0));
		nj.addr3 = ADDR_W'(row1 + (CRD_W + DIM_W + 1)'(x1));
		nj.wx1 = {1'b0, fx};
		nj.wx0 = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fx};
		nj.wy1 = {1'b0, fy};
		nj.wy0 = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fy};
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			job_s2 <= nj;
		end
	end

	assign job_valid = valid_s2;
	assign job       = job_s2;

	a_weights_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (job_s2.wx0 + job_s2.wx1 == (FRAC_W + 1)'(1 << FRAC_W)))
		else $error("horizontal weights do not sum to one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !job_ready) |=> (valid_s2 && $stable(job_s2)))
		else $error("job changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !job_ready) |-> !in_ready)
		else $error("front accepts while full");

endmodule

FILE: hdl/bts_queue.sv
module bts_queue
	import bts_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  bts_job_t wr_job,
	output logic     rd_valid,
	input  logic     rd_ready,
	output bts_job_t rd_job
);

	localparam int PTR_W = $clog2(DEPTH);

	bts_job_t          slots_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic [PTR_W:0]    count_q;
	logic              push, pop;

	assign wr_ready = (count_q != (PTR_W + 1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = slots_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= wr_job;
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W + 1)'(DEPTH))
		else $error("queue overfilled");
	a_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

FILE: hdl/bts_back.sv
module bts_back
	import bts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  bts_job_t    job,
	input  logic [23:0] wr_texel,
	output logic        mem_we,
	output logic [15:0] mem_waddr,
	output logic [23:0] mem_wdata,
	output logic [15:0] mem_raddr_a,
	output logic [15:0] mem_raddr_b,
	input  logic [23:0] mem_rdata_a,
	input  logic [23:0] mem_rdata_b,
	output logic        out_valid,
	input  logic        out_ready,
	output bts_result_t result
);

	// phase_q: 0 takes a job and reads the top pair, 1 reads the bottom pair.
	logic        phase_q;
	bts_job_t    cur_q;
	logic        r1_valid_s1, r1_sample_s1, r1_present_s1;
	logic [16:0] r1_wx0_s1, r1_wx1_s1, r1_wy_s1;
	logic        r2_valid_s2, r2_sample_s2, r2_last_s2;
	logic [16:0] r2_wy_s2;
	logic [25:0] hr_s2, hg_s2, hb_s2;
	logic [41:0] accr_q, accg_q, accb_q;
	logic        out_valid_q;
	bts_result_t res_q;
	logic        stall, take;
	logic        r1_last_s1;
	logic [25:0] hr, hg, hb;
	logic [15:0] ra_q, rb_q;

	// Stall the whole back end while a result is held and the output is not ready.
	assign stall     = out_valid_q && !out_ready;
	assign take      = job_valid && !phase_q && !stall;
	assign job_ready = take;

	assign mem_we    = take && !job.is_sample;
	assign mem_waddr = job.addr0;
	assign mem_wdata = wr_texel;

	// Hold the read addresses while stalled so the read data stays put.
	assign mem_raddr_a = stall ? ra_q : (phase_q ? cur_q.addr2 : job.addr0);
	assign mem_raddr_b = stall ? rb_q : (phase_q ? cur_q.addr3 : job.addr1);

	always_ff @(posedge clk) begin
		ra_q <= mem_raddr_a;
		rb_q <= mem_raddr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			r1_valid_s1 <= 1'b0;
			r2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			phase_q     <= take && job.is_sample;
			r1_valid_s1 <= take || phase_q;
			r2_valid_s2 <= r1_valid_s1;
			out_valid_q <= r2_valid_s2 && r2_last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			if (take) cur_q <= job;
			r1_last_s1    <= phase_q || (take && !job.is_sample);
			r1_sample_s1  <= phase_q ? 1'b1 : job.is_sample;
			r1_present_s1 <= phase_q ? cur_q.present : job.present;
			r1_wx0_s1     <= phase_q ? cur_q.wx0 : job.wx0;
			r1_wx1_s1     <= phase_q ? cur_q.wx1 : job.wx1;
			r1_wy_s1      <= phase_q ? cur_q.wy1 : job.wy0;
		end
	end

	function automatic logic [25:0] hmix(input logic [7:0] a, input logic [7:0] b,
			input logic [16:0] w0, input logic [16:0] w1);
		return 26'(a * w0) + 26'(b * w1);
	endfunction

	logic [7:0] ar, ag, ab, br, bg, bb;

	always_comb begin
		ar = r1_present_s1 ? mem_rdata_a[23:16] : 8'hFF;
		ag = r1_present_s1 ? mem_rdata_a[15:8]  : 8'hFF;
		ab = r1_present_s1 ? mem_rdata_a[7:0]   : 8'hFF;
		br = r1_present_s1 ? mem_rdata_b[23:16] : 8'hFF;
		bg = r1_present_s1 ? mem_rdata_b[15:8]  : 8'hFF;
		bb = r1_present_s1 ? mem_rdata_b[7:0]   : 8'hFF;
		hr = hmix(ar, br, r1_wx0_s1, r1_wx1_s1);
		hg = hmix(ag, bg, r1_wx0_s1, r1_wx1_s1);
		hb = hmix(ab, bb, r1_wx0_s1, r1_wx1_s1);
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			hr_s2         <= hr;
			hg_s2         <= hg;
			hb_s2         <= hb;
			r2_wy_s2      <= r1_wy_s1;
			r2_sample_s2  <= r1_sample_s1;
			r2_last_s2    <= r1_last_s1;
		end
	end

	// Weight by row; the first row seeds the sum, the second finishes it.
	logic [41:0] pr, pg, pb, sr, sg, sb;

	always_comb begin
		pr = 42'(hr_s2 * r2_wy_s2);
		pg = 42'(hg_s2 * r2_wy_s2);
		pb = 42'(hb_s2 * r2_wy_s2);
		sr = pr + accr_q;
		sg = pg + accg_q;
		sb = pb + accb_q;
	end

	always_ff @(posedge clk) begin
		if (!stall && r2_valid_s2) begin
			if (!r2_last_s2) begin
				accr_q <= pr;
				accg_q <= pg;
				accb_q <= pb;
			end else begin
				res_q.was_sample <= r2_sample_s2;
				res_q.red   <= r2_sample_s2 ? sr[39:24] : 16'd0;
				res_q.green <= r2_sample_s2 ? sg[39:24] : 16'd0;
				res_q.blue  <= r2_sample_s2 ? sb[39:24] : 16'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !job_ready)
		else $error("job taken during second read");
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !phase_q)
		else $error("write during a sample read");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(res_q))
		else $error("result changed while stalled");

endmodule

FILE: hdl/bilinear_texture_sampler.sv
// Bilinear texture sampler. Write items (mode 0) store one RGB texel and
// return an acknowledge with was_sample 0; sample items (mode 1) return the
// bilinear blend of four texels in UQ8.8 texel units. A two-stage front end
// scales and clamps coordinates and forms addresses; a four-entry queue feeds
// the back end, which reads the dual-ported texel memory. It reads a sample's
// texels one row at a time (two reads per row) and stores a write directly, so
// it takes no new job while it reads the bottom row of a sample. A result
// passes the read, blend and output registers of the back end. The texel
// memory is not cleared: sample only written texels. Configuration is to be
// written only while the block is idle; the block does not enforce this.
module bilinear_texture_sampler
	import bts_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] texel_address,
	input  logic [7:0]  texel_red,
	input  logic [7:0]  texel_green,
	input  logic [7:0]  texel_blue,
	input  logic [16:0] u_coord,
	input  logic [16:0] v_coord,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sample_red,
	output logic [15:0] sample_green,
	output logic [15:0] sample_blue,
	output logic        was_sample
);

	logic [8:0] tex_width_q, tex_height_q;
	logic       texture_present_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q       <= 9'd1;
			tex_height_q      <= 9'd1;
			texture_present_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:   tex_width_q <= cfg_data;
				REG_HEIGHT:  tex_height_q <= cfg_data;
				REG_PRESENT: texture_present_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// Texel payload travels beside the job through a matching queue.
	localparam int QD = 4;
	localparam int QP = $clog2(QD);

	logic        fj_valid, fj_ready, qj_valid, qj_ready;
	bts_job_t    fj, qj;
	logic [23:0] tx_s1, tx_s2, tq_slots [QD];
	logic [QP-1:0] twp_q, trp_q;
	logic        acc_in, adv1, adv2, v1_q, v2_q;

	bts_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .texel_address, .u_coord,
		.v_coord, .tex_width(tex_width_q), .tex_height(tex_height_q),
		.texture_present(texture_present_q), .job_valid(fj_valid),
		.job_ready(fj_ready), .job(fj)
	);

	// Mirror the front end's two stages for the texel bytes.
	assign acc_in = in_valid && in_ready;
	assign adv2   = !v2_q || fj_ready;
	assign adv1   = !v1_q || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			twp_q <= '0;
			trp_q <= '0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
			if (fj_valid && fj_ready) twp_q <= twp_q + 1'b1;
			if (qj_valid && qj_ready) trp_q <= trp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) tx_s1 <= {texel_red, texel_green, texel_blue};
		if (adv2 && v1_q) tx_s2 <= tx_s1;
		if (fj_valid && fj_ready) tq_slots[twp_q] <= tx_s2;
	end

	bts_queue #(.DEPTH(QD)) u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
	);

	logic        we;
	logic [15:0] waddr, ra, rb;
	logic [23:0] wdata, da, db;
	bts_result_t res;

	bts_back u_back (
		.clk, .arst_n, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
		.wr_texel(tq_slots[trp_q]), .mem_we(we), .mem_waddr(waddr),
		.mem_wdata(wdata), .mem_raddr_a(ra), .mem_raddr_b(rb),
		.mem_rdata_a(da), .mem_rdata_b(db), .out_valid, .out_ready, .result(res)
	);

	bts_ram #(.WIDTH(TEXEL_W), .DEPTH(1 << ADDR_W)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr_a(ra), .raddr_b(rb),
		.rdata_a(da), .rdata_b(db)
	);

	assign sample_red   = res.red;
	assign sample_green = res.green;
	assign sample_blue  = res.blue;
	assign was_sample   = res.was_sample;

	a_stages: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q == u_front.valid_s1) && (v2_q == u_front.valid_s2))
		else $error("texel stage out of step");

endmodule

FILE: tb/bilinear_texture_sampler_checker.sv
module bilinear_texture_sampler_checker
	import bts_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic [15:0] texel_address,
	input  logic [7:0]  texel_red,
	input  logic [7:0]  texel_green,
	input  logic [7:0]  texel_blue,
	input  logic [16:0] u_coord,
	input  logic [16:0] v_coord,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] sample_red,
	input  logic [15:0] sample_green,
	input  logic [15:0] sample_blue,
	input  logic        was_sample,
	output int          errors,
	output int          pending,
	output int          samples_checked
);

	logic [23:0] texels [0:65535];
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;
	logic        present_reg;
	bts_result_t blend_q[$];

	function automatic logic [31:0] clamp_dim(logic [8:0] d);
		if (d == 0) return 32'd1;
		if (d > MAX_DIM) return 32'(MAX_DIM);
		return 32'(d);
	endfunction

	function automatic logic [23:0] texel_at(logic [31:0] x, logic [31:0] y,
			logic [31:0] w, logic [31:0] h);
		logic [31:0] idx;
		if (!present_reg) return 24'hFFFFFF;
		if (x >= w) x = w - 1;
		if (y >= h) y = h - 1;
		idx = (y * w + x) & 32'hFFFF;
		return texels[idx];
	endfunction

	function automatic bts_result_t bilinear(logic [16:0] u, logic [16:0] v);
		bts_result_t r;
		logic [31:0] w, h, x, y;
		logic [63:0] su, sv, fx, fy, acc;
		logic [63:0] wt [4];
		logic [23:0] tx [4];
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		su = 64'(u) * w;
		sv = 64'(v) * h;
		x = 32'(su >> 16);
		y = 32'(sv >> 16);
		fx = su & 64'hFFFF;
		fy = sv & 64'hFFFF;
		wt[0] = (64'd65536 - fx) * (64'd65536 - fy);
		wt[1] = fx * (64'd65536 - fy);
		wt[2] = (64'd65536 - fx) * fy;
		wt[3] = fx * fy;
		tx[0] = texel_at(x, y, w, h);
		tx[1] = texel_at(x + 1, y, w, h);
		tx[2] = texel_at(x, y + 1, w, h);
		tx[3] = texel_at(x + 1, y + 1, w, h);
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += 64'((tx[k] >> (16 - 8 * c)) & 24'hFF) * wt[k];
			case (c)
				0: r.red = acc[39:24];
				1: r.green = acc[39:24];
				default: r.blue = acc[39:24];
			endcase
		end
		r.was_sample = 1'b1;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		samples_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		bts_result_t want;
		if (!arst_n) begin
			width_reg <= 9'd1;
			height_reg <= 9'd1;
			present_reg <= 1'b0;
			blend_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:   width_reg <= cfg_data;
					REG_HEIGHT:  height_reg <= cfg_data;
					REG_PRESENT: present_reg <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_WRITE) begin
					texels[texel_address] = {texel_red, texel_green, texel_blue};
					want = '0;
				end else begin
					want = bilinear(u_coord, v_coord);
				end
				blend_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (blend_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
						$time, sample_red, sample_green, sample_blue, was_sample);
				end else begin
					want = blend_q.pop_front();
					check_field("sample_red", want.red, sample_red);
					check_field("sample_green", want.green, sample_green);
					check_field("sample_blue", want.blue, sample_blue);
					check_field("was_sample", 16'(want.was_sample), 16'(was_sample));
					if (want.was_sample) samples_checked++;
				end
			end
			pending = blend_q.size();
		end
	end

endmodule

FILE: tb/bilinear_texture_sampler_test.sv
module bilinear_texture_sampler_test;
	import bts_pkg::*;

	localparam int MAX_DIM = 256;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [15:0] texel_address;
	logic [7:0]  texel_red;
	logic [7:0]  texel_green;
	logic [7:0]  texel_blue;
	logic [16:0] u_coord;
	logic [16:0] v_coord;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] sample_red;
	logic [15:0] sample_green;
	logic [15:0] sample_blue;
	logic        was_sample;

	int errors;
	int pending;
	int samples_checked;

	bit written [0:65535];
	bit calm;
	bit hold_req;
	logic [8:0] cur_width;
	logic [8:0] cur_height;
	logic       cur_present;
	int         phase_count;

	bilinear_texture_sampler #(.MAX_DIM(MAX_DIM)) dut (.*);

	bilinear_texture_sampler_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random back-pressure, or one long hold-off on request.
	always begin
		@(posedge clk);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (120) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 25);
		end
	end

	function automatic logic [31:0] clamp_dim(logic [8:0] d);
		if (d == 0) return 32'd1;
		if (d > MAX_DIM) return 32'(MAX_DIM);
		return 32'(d);
	endfunction

	task automatic send_item(logic m, logic [15:0] addr, logic [23:0] rgb,
			logic [16:0] u, logic [16:0] v);
		if (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		in_valid <= 1'b1;
		mode <= m;
		texel_address <= addr;
		{texel_red, texel_green, texel_blue} <= rgb;
		u_coord <= u;
		v_coord <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (m == MODE_WRITE) written[addr] = 1'b1;
	endtask

	task automatic write_texel(logic [15:0] addr);
		send_item(MODE_WRITE, addr, 24'($urandom), 17'($urandom), 17'($urandom));
	endtask

	// When a texture is present, make sure the four neighbors of a sample hold written texels first.
	task automatic sample_at(logic [16:0] u, logic [16:0] v);
		logic [31:0] w, h, x, y, xn, yn;
		logic [15:0] idx;
		if (cur_present) begin
			w = clamp_dim(cur_width);
			h = clamp_dim(cur_height);
			x = (32'(u) * w) >> 16;
			y = (32'(v) * h) >> 16;
			for (int k = 0; k < 4; k++) begin
				xn = x + (k & 1);
				yn = y + (k >> 1);
				if (xn >= w) xn = w - 1;
				if (yn >= h) yn = h - 1;
				idx = 16'(yn * w + xn);
				if (!written[idx]) write_texel(idx);
			end
		end
		send_item(MODE_SAMPLE, 16'($urandom), 24'($urandom), u, v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [8:0] w, logic [8:0] h, logic p);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PRESENT, {8'd0, p});
		cur_width = w;
		cur_height = h;
		cur_present = p;
		phase_count++;
	endtask

	function automatic logic [16:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'd65535;
			3: return 17'($urandom_range(65537, 131071));
			4: return 17'($urandom_range(0, 16) * 4096);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 20)
				write_texel(16'($urandom));
			else
				sample_at(pick_coord(), pick_coord());
		end
	endtask

	logic [8:0] widths  [11] = '{1, 256, 0, 300, 256, 1, 7, 3, 16, 200, 511};
	logic [8:0] heights [11] = '{1, 256, 256, 1, 0, 511, 5, 9, 16, 130, 2};
	logic       presents[11] = '{1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1};

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_WRITE;
		texel_address = '0;
		texel_red = '0;
		texel_green = '0;
		texel_blue = '0;
		u_coord = '0;
		v_coord = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_width = 9'd1;
		cur_height = 9'd1;
		cur_present = 1'b0;
		phase_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No texture after reset: everything reads white.
		send_item(MODE_SAMPLE, 16'hFFFF, 24'hFFFFFF, 17'd0, 17'd0);
		send_item(MODE_SAMPLE, 16'h0000, 24'h000000, 17'h1FFFF, 17'd65536);
		send_item(MODE_WRITE, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF, 17'h1FFFF);
		send_item(MODE_WRITE, 16'h0000, 24'h000000, 17'd0, 17'd0);

		configure(9'd2, 9'd2, 1'b1);
		send_item(MODE_WRITE, 16'd1, 24'hFF0000, 17'd0, 17'd0);
		send_item(MODE_WRITE, 16'd2, 24'h00FF00, 17'd0, 17'd0);
		send_item(MODE_WRITE, 16'd3, 24'h0000FF, 17'd0, 17'd0);
		sample_at(17'd0, 17'd0);
		sample_at(17'd32768, 17'd32768);
		sample_at(17'd65535, 17'd65535);
		sample_at(17'd65536, 17'd0);
		sample_at(17'h1FFFF, 17'h1FFFF);
		sample_at(17'd16384, 17'd49152);
		sample_at(17'd1, 17'd65534);

		for (int p = 0; p < 11; p++) begin
			configure(widths[p], heights[p], presents[p]);
			if (p == 4) begin
				calm = 1'b1;
				random_items(30);
				calm = 1'b0;
			end else if (p == 6) begin
				hold_req = 1'b1;
				random_items(30);
			end else begin
				random_items(30);
			end
		end
		drain();

		$display("checked %0d samples and all write acknowledges over %0d register settings",
			samples_checked, phase_count);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
